// ----- src/vcc_pkg.sv -----
`default_nettype none
package vcc_pkg;

    localparam int NUM_PRODUCTS_DEF   = 32;
    localparam int NUM_COIN_KINDS_DEF = 8;
    // Only 32 slots can be addressed by the 5-bit product field.
    localparam int TABLE_MAX          = 32;
    localparam int MAX_LINES          = 5;
    localparam int QUEUE_DEPTH        = 2;

    typedef enum logic [1:0] {
        OP_SELECT = 2'd0,
        OP_COIN   = 2'd1,
        OP_LOAD   = 2'd2
    } t_opcode;

    typedef enum logic [3:0] {
        ST_DUE      = 4'd0,
        ST_COIN_REJ = 4'd1,
        ST_NO_STOCK = 4'd2,
        ST_VENDED   = 4'd3,
        ST_CHANGE   = 4'd4,
        ST_NO_SALE  = 4'd5,
        ST_BUSY     = 4'd6,
        ST_LOADED   = 4'd7,
        ST_STARTED  = 4'd8
    } t_status;

    typedef enum logic {
        F_IDLE,
        F_EXEC
    } t_fstate;

    typedef enum logic [2:0] {
        B_IDLE,
        B_ONE,
        B_CALC,
        B_VEND,
        B_LINES
    } t_bstate;

    // One command from the front to the back. A vend command carries the
    // total change in amount; any other command is a single finished result.
    typedef struct packed {
        logic        is_vend;
        t_status     status;
        logic [4:0]  slot;
        logic [13:0] amount;
    } t_cmd;

    function automatic int clamp_kinds(input int k);
        int r;
        r = k;
        if (r < 1) r = 1;
        if (r > 8) r = 8;
        return r;
    endfunction

    // Denominations in cents, largest first.
    function automatic logic [7:0] denom(input logic [2:0] idx);
        logic [7:0] d;
        unique case (idx)
            3'd0: d = 8'd200;
            3'd1: d = 8'd100;
            3'd2: d = 8'd50;
            3'd3: d = 8'd20;
            3'd4: d = 8'd10;
            3'd5: d = 8'd5;
            3'd6: d = 8'd2;
            3'd7: d = 8'd1;
        endcase
        return d;
    endfunction

    function automatic logic coin_valid(input logic [7:0] coin, input int kinds);
        logic ok;
        ok = 1'b0;
        for (int i = 0; i < 8; i++) begin
            if ((i < kinds) && (coin == denom(3'(i)))) ok = 1'b1;
        end
        return ok;
    endfunction

endpackage
`default_nettype wire

// ----- src/vending_coin_change_controller_core.sv -----
// Vending controller with greedy change, all money in integer cents.
// The input channel (i_in_valid / o_in_ready) takes one event word per
// handshake: select a product, insert a coin, or load a slot's price and stock.
// The output channel (o_out_valid / i_out_ready) gives result words; every
// event gives one result word, except a completed sale, which gives a vend word
// followed by up to five change-line words, and opcode 3, which gives nothing.
// o_last marks the final result word of each event.
// The front accepts an event, then reads the tables (registered) and decides,
// and takes no new event before that is done; it waits while the queue is full.
// The back pops a command and writes one result word, or for a sale first does
// greedy change work (one denomination per cycle), then writes the vend and
// change-line words, each held while the output stalls. A two-word queue between
// front and back lets the front keep taking events while change lines drain.
// Reset clears the sale state, the valid bits of the price and stock tables
// (so every slot reads as zero price and zero stock) and all handshakes.
// When the receiver holds i_out_ready low, the result word stays put; the back
// then stops, the queue fills and the front finally drops o_in_ready.
`default_nettype none
module vending_coin_change_controller_core #(
    parameter int NUM_PRODUCTS   = vcc_pkg::NUM_PRODUCTS_DEF,
    parameter int NUM_COIN_KINDS = vcc_pkg::NUM_COIN_KINDS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_opcode,
    input  logic [4:0]  i_product,
    input  logic [7:0]  i_coin_cents,
    input  logic [13:0] i_load_price,
    input  logic [7:0]  i_load_quantity,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_status,
    output logic [4:0]  o_slot,
    output logic [13:0] o_amount,
    output logic [7:0]  o_coin_count,
    output logic        o_last
);
    import vcc_pkg::*;

    // Commands crossing from the event front to the result back.
    t_cmd push_cmd;
    t_cmd pop_cmd;
    logic push;
    logic pop;
    logic q_full;
    logic q_empty;

    // The front owns all sale state and both tables, so an event is fully
    // decided before the back has finished paying out the previous one.
    vcc_front #(
        .NUM_PRODUCTS   (NUM_PRODUCTS),
        .NUM_COIN_KINDS (NUM_COIN_KINDS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_opcode        (i_opcode),
        .i_product       (i_product),
        .i_coin_cents    (i_coin_cents),
        .i_load_price    (i_load_price),
        .i_load_quantity (i_load_quantity),
        .o_push          (push),
        .o_cmd           (push_cmd),
        .i_full          (q_full)
    );

    vcc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_cmd   (pop_cmd),
        .o_empty (q_empty)
    );

    // The back breaks the change into denominations and drives the output
    // register, which holds its word while the receiver stalls.
    vcc_back #(
        .NUM_COIN_KINDS (NUM_COIN_KINDS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (pop_cmd),
        .i_empty      (q_empty),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_slot       (o_slot),
        .o_amount     (o_amount),
        .o_coin_count (o_coin_count),
        .o_last       (o_last)
    );

endmodule
`default_nettype wire

// ----- src/vcc_front.sv -----
`default_nettype none
module vcc_front #(
    parameter int NUM_PRODUCTS   = vcc_pkg::NUM_PRODUCTS_DEF,
    parameter int NUM_COIN_KINDS = vcc_pkg::NUM_COIN_KINDS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_opcode,
    input  logic [4:0]        i_product,
    input  logic [7:0]        i_coin_cents,
    input  logic [13:0]       i_load_price,
    input  logic [7:0]        i_load_quantity,
    output logic              o_push,
    output vcc_pkg::t_cmd     o_cmd,
    input  logic              i_full
);
    import vcc_pkg::*;

    localparam int DEPTH = (NUM_PRODUCTS < TABLE_MAX) ? NUM_PRODUCTS : TABLE_MAX;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int KINDS = clamp_kinds(NUM_COIN_KINDS);

    t_fstate          r_state, n_state;
    logic [1:0]       r_op;
    logic [4:0]       r_prod;
    logic [7:0]       r_coin;
    logic [13:0]      r_lprice;
    logic [7:0]       r_lqty;
    logic [AW-1:0]    r_addr;
    logic             r_sale_open, n_sale_open;
    logic [4:0]       r_cur_slot, n_cur_slot;
    logic [13:0]      r_due, n_due;

    logic [13:0]      price_mem [DEPTH];
    logic [7:0]       stock_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [13:0]      r_price_rd;
    logic [7:0]       r_stock_rd;
    logic             r_hit_rd;

    logic             accept;
    logic [AW-1:0]    rd_addr;
    logic [13:0]      price_eff;
    logic [7:0]       stock_eff;
    logic             inrange;
    logic             need_res;
    logic             go;
    logic             do_load;
    logic             do_dec;
    t_cmd             cmd;

    assign accept  = i_in_valid && o_in_ready;
    // A coin works on the open sale's slot, everything else on the product field.
    assign rd_addr = (i_opcode == OP_COIN) ? r_cur_slot[AW-1:0] : i_product[AW-1:0];

    assign price_eff = r_hit_rd ? r_price_rd : 14'd0;
    assign stock_eff = r_hit_rd ? r_stock_rd : 8'd0;
    assign inrange   = int'(r_prod) < NUM_PRODUCTS;

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        n_sale_open = r_sale_open;
        n_cur_slot  = r_cur_slot;
        n_due       = r_due;
        need_res    = 1'b0;
        do_load     = 1'b0;
        do_dec      = 1'b0;
        go          = 1'b0;
        cmd.is_vend = 1'b0;
        cmd.status  = ST_DUE;
        cmd.slot    = r_cur_slot;
        cmd.amount  = 14'd0;

        unique case (r_op)
            OP_SELECT: begin
                need_res = 1'b1;
                if (r_sale_open) begin
                    cmd.status = ST_BUSY;
                    cmd.amount = r_due;
                end else if (!inrange || (stock_eff == 8'd0)) begin
                    cmd.status = ST_NO_STOCK;
                    cmd.slot   = r_prod;
                end else if (price_eff == 14'd0) begin
                    // Free product: vend at once with no change.
                    cmd.is_vend = 1'b1;
                    cmd.status  = ST_VENDED;
                    cmd.slot    = r_prod;
                    n_cur_slot  = r_prod;
                    do_dec      = 1'b1;
                end else begin
                    cmd.status  = ST_STARTED;
                    cmd.slot    = r_prod;
                    cmd.amount  = price_eff;
                    n_sale_open = 1'b1;
                    n_cur_slot  = r_prod;
                    n_due       = price_eff;
                end
            end
            OP_COIN: begin
                need_res = 1'b1;
                if (!r_sale_open) begin
                    cmd.status = ST_NO_SALE;
                end else if (!coin_valid(r_coin, KINDS)) begin
                    cmd.status = ST_COIN_REJ;
                    cmd.amount = r_due;
                end else if ({6'd0, r_coin} >= r_due) begin
                    cmd.is_vend = 1'b1;
                    cmd.status  = ST_VENDED;
                    cmd.amount  = {6'd0, r_coin} - r_due;
                    n_sale_open = 1'b0;
                    n_due       = 14'd0;
                    do_dec      = 1'b1;
                end else begin
                    n_due      = r_due - {6'd0, r_coin};
                    cmd.status = ST_DUE;
                    cmd.amount = r_due - {6'd0, r_coin};
                end
            end
            OP_LOAD: begin
                need_res = 1'b1;
                cmd.slot = r_prod;
                if (inrange) begin
                    cmd.status = ST_LOADED;
                    cmd.amount = r_lprice;
                    do_load    = 1'b1;
                end else begin
                    cmd.status = ST_NO_STOCK;
                end
            end
            default: begin
                need_res = 1'b0;
            end
        endcase

        unique case (r_state)
            F_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) n_state = F_EXEC;
            end
            F_EXEC: begin
                go = !need_res || !i_full;
                if (go) n_state = F_IDLE;
            end
            default: n_state = F_IDLE;
        endcase

        if (!go) begin
            n_sale_open = r_sale_open;
            n_cur_slot  = r_cur_slot;
            n_due       = r_due;
        end
    end

    assign o_push = go && need_res;
    assign o_cmd  = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= F_IDLE;
            r_sale_open <= 1'b0;
            r_cur_slot  <= 5'd0;
            r_due       <= 14'd0;
            r_valid     <= '0;
        end else begin
            r_state     <= n_state;
            r_sale_open <= n_sale_open;
            r_cur_slot  <= n_cur_slot;
            r_due       <= n_due;
            if (go && do_load) r_valid[r_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op       <= i_opcode;
            r_prod     <= i_product;
            r_coin     <= i_coin_cents;
            r_lprice   <= i_load_price;
            r_lqty     <= i_load_quantity;
            r_addr     <= rd_addr;
            r_price_rd <= price_mem[rd_addr];
            r_stock_rd <= stock_mem[rd_addr];
            r_hit_rd   <= r_valid[rd_addr];
        end
        if (go && do_load) begin
            price_mem[r_addr] <= r_lprice;
            stock_mem[r_addr] <= r_lqty;
        end else if (go && do_dec && (stock_eff != 8'd0)) begin
            stock_mem[r_addr] <= stock_eff - 8'd1;
        end
    end

endmodule
`default_nettype wire

// ----- src/vcc_queue.sv -----
`default_nettype none
module vcc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  vcc_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output vcc_pkg::t_cmd o_cmd,
    output logic          o_empty
);
    import vcc_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_cmd          r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_full  = r_count == CW'(QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) r_count <= r_count + 1'b1;
            else if (i_pop && !i_push) r_count <= r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_cmd;
    end

endmodule
`default_nettype wire

// ----- src/vcc_back.sv -----
`default_nettype none
module vcc_back #(
    parameter int NUM_COIN_KINDS = vcc_pkg::NUM_COIN_KINDS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  vcc_pkg::t_cmd i_cmd,
    input  logic          i_empty,
    output logic          o_pop,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic [3:0]    o_status,
    output logic [4:0]    o_slot,
    output logic [13:0]   o_amount,
    output logic [7:0]    o_coin_count,
    output logic          o_last
);
    import vcc_pkg::*;

    localparam int         KINDS  = clamp_kinds(NUM_COIN_KINDS);
    localparam logic [7:0] D_LAST = denom(3'(KINDS - 1));
    localparam int         DL     = int'(D_LAST);

    // Value of one coin of each kind counted in the smallest accepted coin.
    function automatic logic [7:0] tail_ratio(input logic [2:0] idx);
        logic [7:0] r;
        unique case (idx)
            3'd0: r = 8'(200 / DL);
            3'd1: r = 8'(100 / DL);
            3'd2: r = 8'(50 / DL);
            3'd3: r = 8'(20 / DL);
            3'd4: r = 8'(10 / DL);
            3'd5: r = 8'(5 / DL);
            3'd6: r = 8'(2 / DL);
            3'd7: r = 8'(1 / DL);
        endcase
        return r;
    endfunction

    t_bstate     r_state, n_state;
    t_cmd        r_cmd;
    logic [7:0]  r_rem;
    logic [2:0]  r_idx;
    logic [3:0]  r_raw;
    logic [7:0]  r_left;
    logic [2:0]  r_j, n_j;
    logic [7:0]  r_den [MAX_LINES];
    logic [7:0]  r_cnt [MAX_LINES];

    logic        r_out_valid;
    t_status     r_status;
    logic [4:0]  r_slot;
    logic [13:0] r_amount;
    logic [7:0]  r_count;
    logic        r_last;

    logic        out_free;
    logic        calc;
    logic        emit;
    t_status     e_status;
    logic [13:0] e_amount;
    logic [7:0]  e_count;
    logic        e_last;
    logic [7:0]  den_cur;
    logic [8:0]  den_two;
    logic [7:0]  quo;
    logic [7:0]  used;
    logic [2:0]  nlines;
    logic        folded;
    logic [7:0]  line_den;
    logic [7:0]  line_cnt;

    assign out_free = !r_out_valid || i_out_ready;
    assign den_cur  = denom(r_idx);
    assign den_two  = {den_cur, 1'b0};
    assign folded   = r_raw > 4'(MAX_LINES);
    assign nlines   = folded ? 3'(MAX_LINES) : r_raw[2:0];

    // The remainder entering each denomination is below the previous one,
    // so at most two coins of any kind fit and two compares give the count.
    always_comb begin
        if ({1'b0, r_rem} >= den_two) begin
            quo  = 8'd2;
            used = den_two[7:0];
        end else if (r_rem >= den_cur) begin
            quo  = 8'd1;
            used = den_cur;
        end else begin
            quo  = 8'd0;
            used = 8'd0;
        end
    end

    // When greedy change needs more lines than fit, the last line pays the
    // whole tail in the smallest accepted coin. r_left already counts that
    // tail in smallest coins.
    always_comb begin
        if (folded && (r_j == 3'(MAX_LINES - 1))) begin
            line_den = D_LAST;
            line_cnt = r_left;
        end else begin
            line_den = r_den[r_j];
            line_cnt = r_cnt[r_j];
        end
    end

    always_comb begin
        n_state  = r_state;
        n_j      = r_j;
        o_pop    = 1'b0;
        calc     = 1'b0;
        emit     = 1'b0;
        e_status = r_cmd.status;
        e_amount = r_cmd.amount;
        e_count  = 8'd0;
        e_last   = 1'b1;
        unique case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_state = i_cmd.is_vend ? B_CALC : B_ONE;
                end
            end
            B_ONE: begin
                if (out_free) begin
                    emit    = 1'b1;
                    n_state = B_IDLE;
                end
            end
            B_CALC: begin
                calc = 1'b1;
                if (r_idx == 3'(KINDS - 1)) n_state = B_VEND;
            end
            B_VEND: begin
                if (out_free) begin
                    emit     = 1'b1;
                    e_status = ST_VENDED;
                    e_last   = r_raw == 4'd0;
                    n_j      = 3'd0;
                    n_state  = (r_raw == 4'd0) ? B_IDLE : B_LINES;
                end
            end
            B_LINES: begin
                if (out_free) begin
                    emit     = 1'b1;
                    e_status = ST_CHANGE;
                    e_amount = {6'd0, line_den};
                    e_count  = line_cnt;
                    e_last   = r_j == (nlines - 3'd1);
                    n_j      = r_j + 3'd1;
                    if (e_last) n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_j <= n_j;
        if (o_pop) begin
            r_cmd  <= i_cmd;
            r_rem  <= i_cmd.amount[7:0];
            r_idx  <= 3'd0;
            r_raw  <= 4'd0;
            r_left <= 8'd0;
        end
        if (calc) begin
            r_idx <= r_idx + 3'd1;
            r_rem <= r_rem - used;
            if (quo != 8'd0) begin
                r_raw <= r_raw + 4'd1;
                if (r_raw < 4'(MAX_LINES)) begin
                    r_den[r_raw[2:0]] <= den_cur;
                    r_cnt[r_raw[2:0]] <= quo;
                end
                if (r_raw >= 4'(MAX_LINES - 1)) begin
                    r_left <= r_left + 8'(quo * tail_ratio(r_idx));
                end
            end
        end
        if (emit) begin
            r_status <= e_status;
            r_slot   <= r_cmd.slot;
            r_amount <= e_amount;
            r_count  <= e_count;
            r_last   <= e_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_slot       = r_slot;
    assign o_amount     = r_amount;
    assign o_coin_count = r_count;
    assign o_last       = r_last;

endmodule
`default_nettype wire

// ----- src/vcc_checker.sv -----
`default_nettype none
module vcc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [3:0]  o_status,
    input logic [13:0] o_amount,
    input logic [7:0]  o_coin_count,
    input logic        o_last
);
    import vcc_pkg::*;

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status) && $stable(o_amount))
        else $error("result word changed while stalled");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("handshakes not cleared by reset");

    // A vend word is followed by its change lines, so among non-change words only it may be non-final.
    a_count_only_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_CHANGE) |->
            (o_coin_count == 8'd0) && (o_last || (o_status == ST_VENDED)))
        else $error("non-change result with coin count or not final");

    a_change_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_CHANGE) |-> (o_coin_count != 8'd0) && (o_amount != 14'd0))
        else $error("empty change line");

endmodule

bind vending_coin_change_controller_core vcc_checker u_vcc_checker (.*);
`default_nettype wire

// ----- dv/vending_coin_change_controller_core_tb.sv -----
`default_nettype none
module vending_coin_change_controller_core_tb;

    import vcc_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int SLOTS        = NUM_PRODUCTS_DEF;
    localparam int COIN_KINDS   = NUM_COIN_KINDS_DEF;
    localparam int LINE_LIMIT   = MAX_LINES;
    localparam int PAID_CEILING = 16383;
    localparam int HOLD_LEN     = 300;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int SETTLE_LEN   = 64;
    localparam int ERROR_PRINTS = 100;

    // Opcode 3 is not decoded by the block and must produce no result word.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Accepted coin values in cents, largest first.
    localparam int COIN_VALUES [8] = '{200, 100, 50, 20, 10, 5, 2, 1};

    typedef struct packed {
        t_status     status;
        logic [4:0]  slot;
        logic [13:0] amount;
        logic [7:0]  coin_count;
        logic        last;
    } t_result;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic [1:0]  in_opcode = '0;
    logic [4:0]  in_product = '0;
    logic [7:0]  in_coin   = '0;
    logic [13:0] in_price  = '0;
    logic [7:0]  in_qty    = '0;
    logic        out_ready = 1'b0;

    wire         in_ready;
    wire         out_valid;
    wire [3:0]   out_status;
    wire [4:0]   out_slot;
    wire [13:0]  out_amount;
    wire [7:0]   out_coin_count;
    wire         out_last;

    vending_coin_change_controller_core dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_opcode        (in_opcode),
        .i_product       (in_product),
        .i_coin_cents    (in_coin),
        .i_load_price    (in_price),
        .i_load_quantity (in_qty),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_status        (out_status),
        .o_slot          (out_slot),
        .o_amount        (out_amount),
        .o_coin_count    (out_coin_count),
        .o_last          (out_last)
    );

    always begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Shadow copy of the machine state, advanced at every accepted word.
    logic [13:0] price_tbl [SLOTS];
    logic [7:0]  stock_tbl [SLOTS];
    bit          sale_open;
    logic [4:0]  sale_slot;
    int          sale_due;
    int          sale_paid;

    t_result expected_q [$];

    int error_count    = 0;
    int words_sent     = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_requests  = 0;

    function automatic void emit_result(input t_status st, input logic [4:0] slot,
                                        input logic [13:0] amount, input int coins);
        t_result w;
        w.status     = st;
        w.slot       = slot;
        w.amount     = amount;
        w.coin_count = (coins > 255) ? 8'd255 : 8'(coins);
        w.last       = 1'b0;
        expected_q.push_back(w);
    endfunction

    // Closes the sale: one vend word with the total change, then greedy
    // change lines. When more than five denominations are needed, the fifth
    // line pays the whole remainder in the smallest accepted coin.
    function automatic void close_sale(input logic [4:0] slot, input int change);
        int den [8];
        int cnt [8];
        int lines;
        int rem;
        int left;
        lines = 0;
        rem   = change;
        if (stock_tbl[slot] != 0) stock_tbl[slot] = stock_tbl[slot] - 8'd1;
        sale_open = 1'b0;
        sale_due  = 0;
        for (int i = 0; i < COIN_KINDS; i++) begin
            if (rem / COIN_VALUES[i] != 0) begin
                den[lines] = COIN_VALUES[i];
                cnt[lines] = rem / COIN_VALUES[i];
                rem        = rem - cnt[lines] * COIN_VALUES[i];
                lines++;
            end
        end
        if (lines > LINE_LIMIT) begin
            left = 0;
            for (int i = LINE_LIMIT - 1; i < lines; i++) left += den[i] * cnt[i];
            den[LINE_LIMIT - 1] = COIN_VALUES[COIN_KINDS - 1];
            cnt[LINE_LIMIT - 1] = left / COIN_VALUES[COIN_KINDS - 1];
            lines = LINE_LIMIT;
        end
        emit_result(ST_VENDED, slot, 14'(change), 0);
        for (int i = 0; i < lines; i++) emit_result(ST_CHANGE, slot, 14'(den[i]), cnt[i]);
    endfunction

    function automatic void predict_event(input logic [1:0] op, input logic [4:0] prod,
                                          input logic [7:0] coin, input logic [13:0] price,
                                          input logic [7:0] qty);
        int  first;
        bit  coin_ok;
        bit  in_range;
        first    = expected_q.size();
        coin_ok  = 1'b0;
        in_range = (int'(prod) < SLOTS);
        case (op)
            OP_SELECT: begin
                if (sale_open) begin
                    emit_result(ST_BUSY, sale_slot, 14'(sale_due), 0);
                end else if (!in_range || stock_tbl[prod] == 0) begin
                    emit_result(ST_NO_STOCK, prod, 14'd0, 0);
                end else if (price_tbl[prod] == 0) begin
                    // A free product vends on the spot with no change.
                    sale_paid = 0;
                    sale_slot = prod;
                    close_sale(prod, 0);
                end else begin
                    sale_open = 1'b1;
                    sale_slot = prod;
                    sale_due  = int'(price_tbl[prod]);
                    sale_paid = 0;
                    emit_result(ST_STARTED, prod, 14'(sale_due), 0);
                end
            end
            OP_COIN: begin
                for (int i = 0; i < COIN_KINDS; i++) begin
                    if (int'(coin) == COIN_VALUES[i]) coin_ok = 1'b1;
                end
                if (!sale_open) begin
                    emit_result(ST_NO_SALE, sale_slot, 14'd0, 0);
                end else if (!coin_ok) begin
                    emit_result(ST_COIN_REJ, sale_slot, 14'(sale_due), 0);
                end else begin
                    sale_paid += int'(coin);
                    if (sale_paid > PAID_CEILING) sale_paid = PAID_CEILING;
                    if (int'(coin) >= sale_due) begin
                        close_sale(sale_slot, int'(coin) - sale_due);
                    end else begin
                        sale_due -= int'(coin);
                        emit_result(ST_DUE, sale_slot, 14'(sale_due), 0);
                    end
                end
            end
            OP_LOAD: begin
                if (in_range) begin
                    price_tbl[prod] = price;
                    stock_tbl[prod] = qty;
                    emit_result(ST_LOADED, prod, price, 0);
                end else begin
                    emit_result(ST_NO_STOCK, prod, 14'd0, 0);
                end
            end
            default: begin
            end
        endcase
        if (expected_q.size() > first) expected_q[expected_q.size() - 1].last = 1'b1;
    endfunction

    // Offers one event word and returns at the edge where it is taken. The
    // valid line stays high on return so that back-to-back words need no
    // second assignment to it within one step.
    task automatic send_event(input logic [1:0] op, input logic [4:0] prod,
                              input logic [7:0] coin, input logic [13:0] price,
                              input logic [7:0] qty);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid   <= 1'b1;
        in_opcode  <= op;
        in_product <= prod;
        in_coin    <= coin;
        in_price   <= price;
        in_qty     <= qty;
        do @(posedge clk); while (!in_ready);
        predict_event(op, prod, coin, price, qty);
        words_sent++;
    endtask

    // The receiver normally stalls at random; a hold request makes it refuse
    // every result word while the hold lasts.
    initial begin : receiver
        int hold_left;
        int hold_served;
        hold_left   = 0;
        hold_served = 0;
        forever begin
            @(posedge clk);
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                hold_left   = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic check_field(input string name, input logic [13:0] want,
                               input logic [13:0] got);
        if (got !== want) begin
            error_count++;
            // Keep the log readable when the block is badly broken.
            if (error_count <= ERROR_PRINTS) begin
                $error("%s mismatch: expected %0d, got %0d", name, want, got);
            end
        end
    endtask

    always @(posedge clk) begin : check_results
        t_result want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_q.size() == 0) begin
                error_count++;
                if (error_count <= ERROR_PRINTS) begin
                    $error("result word with none expected: status %0d slot %0d amount %0d",
                           out_status, out_slot, out_amount);
                end
            end else begin
                want = expected_q.pop_front();
                check_field("status", 14'(want.status), 14'(out_status));
                check_field("slot", 14'(want.slot), 14'(out_slot));
                check_field("amount", want.amount, out_amount);
                check_field("coin_count", 14'(want.coin_count), 14'(out_coin_count));
                check_field("last", 14'(want.last), 14'(out_last));
            end
        end
    end

    function automatic logic [13:0] pick_price();
        int r;
        r = $urandom_range(99);
        if (r < 8) return 14'd0;
        if (r < 90) return 14'($urandom_range(300, 1));
        return 14'($urandom_range(9999, 301));
    endfunction

    function automatic logic [7:0] pick_quantity();
        int r;
        r = $urandom_range(9);
        if (r == 0) return 8'd0;
        if (r < 3) return 8'd1;
        return 8'($urandom_range(255, 1));
    endfunction

    // Large dues are mostly paid in the largest coin to keep sales short.
    function automatic logic [7:0] pick_coin();
        if (sale_due > 400 && $urandom_range(3) != 0) return 8'(COIN_VALUES[0]);
        return 8'(COIN_VALUES[$urandom_range(COIN_KINDS - 1)]);
    endfunction

    // One well-formed sale: restock if needed, select, then pay until the
    // product vends, with occasional bad coins, busy selects, loads and noise.
    task automatic run_sale();
        logic [4:0] slot;
        int         guard;
        int         pick;
        slot = 5'($urandom_range(SLOTS - 1));
        if (stock_tbl[slot] == 0 || $urandom_range(9) == 0) begin
            send_event(OP_LOAD, slot, 8'($urandom), pick_price(), pick_quantity());
        end
        send_event(OP_SELECT, slot, 8'($urandom), 14'($urandom), 8'($urandom));
        guard = 0;
        while (sale_open && guard < 200) begin
            pick = $urandom_range(99);
            if (pick < 84) begin
                send_event(OP_COIN, 5'($urandom), pick_coin(), 14'($urandom), 8'($urandom));
            end else if (pick < 89) begin
                send_event(OP_COIN, 5'($urandom), 8'($urandom), 14'($urandom),
                           8'($urandom));
            end else if (pick < 93) begin
                send_event(OP_SELECT, 5'($urandom), 8'($urandom), 14'($urandom),
                           8'($urandom));
            end else if (pick < 97) begin
                send_event(OP_LOAD, 5'($urandom), 8'($urandom), pick_price(),
                           pick_quantity());
            end else begin
                send_event(OP_UNUSED, 5'($urandom), 8'($urandom), 14'($urandom),
                           8'($urandom));
            end
            guard++;
        end
    endtask

    task automatic test_directed_cases();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // Coin before any sale, unused opcode, select of an empty slot.
        send_event(OP_COIN, 5'd3, 8'd5, 14'($urandom), 8'($urandom));
        send_event(OP_UNUSED, 5'($urandom), 8'($urandom), 14'($urandom), 8'($urandom));
        send_event(OP_SELECT, 5'd5, 8'($urandom), 14'($urandom), 8'($urandom));
        // Extreme load values, then a free product that vends at once.
        send_event(OP_LOAD, 5'd31, 8'($urandom), 14'd9999, 8'd255);
        send_event(OP_LOAD, 5'd0, 8'($urandom), 14'd0, 8'd1);
        send_event(OP_SELECT, 5'd0, 8'($urandom), 14'($urandom), 8'($urandom));
        send_event(OP_SELECT, 5'd0, 8'($urandom), 14'($urandom), 8'($urandom));
        // A sale with a busy select, bad coins and a load in the middle.
        send_event(OP_LOAD, 5'd7, 8'($urandom), 14'd12, 8'd1);
        send_event(OP_SELECT, 5'd7, 8'($urandom), 14'($urandom), 8'($urandom));
        send_event(OP_SELECT, 5'd31, 8'($urandom), 14'($urandom), 8'($urandom));
        send_event(OP_COIN, 5'($urandom), 8'd3, 14'($urandom), 8'($urandom));
        send_event(OP_COIN, 5'($urandom), 8'd0, 14'($urandom), 8'($urandom));
        send_event(OP_COIN, 5'($urandom), 8'd255, 14'($urandom), 8'($urandom));
        send_event(OP_LOAD, 5'd9, 8'($urandom), 14'd1, 8'd2);
        send_event(OP_COIN, 5'($urandom), 8'd1, 14'($urandom), 8'($urandom));
        // Change of 189 cents needs six denominations; the tail is folded.
        send_event(OP_COIN, 5'($urandom), 8'd200, 14'($urandom), 8'($urandom));
        // Change of 199 cents fills exactly five lines.
        send_event(OP_SELECT, 5'd9, 8'($urandom), 14'($urandom), 8'($urandom));
        send_event(OP_COIN, 5'($urandom), 8'd200, 14'($urandom), 8'($urandom));
        send_event(OP_COIN, 5'($urandom), 8'd2, 14'($urandom), 8'($urandom));
        // Last unit of a slot: the select after the sale finds it empty.
        send_event(OP_LOAD, 5'd20, 8'($urandom), 14'd50, 8'd1);
        send_event(OP_SELECT, 5'd20, 8'($urandom), 14'($urandom), 8'($urandom));
        send_event(OP_COIN, 5'($urandom), 8'd50, 14'($urandom), 8'($urandom));
        send_event(OP_SELECT, 5'd20, 8'($urandom), 14'($urandom), 8'($urandom));
    endtask

    task automatic test_random_sales(input int idle_pct, input int stall_pct, input int count);
        int target;
        int noise;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        target = words_sent + count;
        while (words_sent < target) begin
            noise = $urandom_range(9);
            if (noise == 0) begin
                send_event(OP_COIN, 5'($urandom), 8'($urandom), 14'($urandom),
                           8'($urandom));
            end else if (noise == 1) begin
                send_event(OP_UNUSED, 5'($urandom), 8'($urandom), 14'($urandom),
                           8'($urandom));
            end else begin
                run_sale();
            end
        end
    endtask

    // The receiver refuses everything for a long stretch while the sender
    // keeps offering sales, so the block fills and drops its input ready.
    task automatic test_output_backpressure();
        int target;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_requests++;
        target = words_sent + 30;
        while (words_sent < target) run_sale();
    endtask

    task automatic test_pause_until_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_q.size() != 0);
    endtask

    initial begin : stimulus
        int wait_cycles;
        for (int i = 0; i < SLOTS; i++) begin
            price_tbl[i] = '0;
            stock_tbl[i] = '0;
        end
        sale_open = 1'b0;
        sale_slot = '0;
        sale_due  = 0;
        sale_paid = 0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_random_sales(0, 0, 80);
        test_random_sales(84, 0, 80);
        test_pause_until_drained();
        test_random_sales(0, 84, 80);
        test_output_backpressure();
        test_random_sales(35, 35, 80);

        in_valid <= 1'b0;
        wait_cycles = 0;
        do begin
            @(posedge clk);
            wait_cycles++;
        end while (expected_q.size() != 0 && wait_cycles < DRAIN_LIMIT);
        // An unused opcode may still be in flight; give stray words time to show.
        repeat (SETTLE_LEN) @(posedge clk);

        if (expected_q.size() != 0) begin
            $error("%0d expected result words never arrived", expected_q.size());
        end
        if (error_count == 0 && expected_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin : watchdog
        #(2 * CLK_HALF * 1000000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
`default_nettype wire

// ----- filelist.f -----
src/vcc_pkg.sv
src/vcc_front.sv
src/vcc_queue.sv
src/vcc_back.sv
src/vending_coin_change_controller_core.sv
src/vcc_checker.sv
dv/vending_coin_change_controller_core_tb.sv
